@@ hdl/adpcmnd_pkg.sv @@
// adpcmnd_pkg: constants, tables and types for the ADPCM nibble decoder.
// Used by adpcmnd_nibble and adpcm_nibble_decoder; depends on nothing.
package adpcmnd_pkg;

    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned SampleW   = 16;
    localparam int unsigned StepIdxW  = 7;
    localparam int unsigned StepW     = 15;

    localparam logic [CfgIdxW-1:0] CFG_START_PRED = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_START_SIDX = 2'd1;

    localparam logic [StepIdxW-1:0] STEP_IDX_MAX = 7'd88;

    localparam logic [StepW-1:0] STEP_ROM [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
        15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
        15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
        15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
        15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
        15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
        15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
        15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
        15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
        15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
        15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [4:0] INDEX_ADJ [0:15] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8,
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    typedef struct packed {
        logic signed [SampleW-1:0] pred;
        logic [StepIdxW-1:0]       sidx;
    } t_dec_state;

    function automatic logic [StepIdxW-1:0] clamp_idx(input logic [StepIdxW-1:0] v);
        return (v > STEP_IDX_MAX) ? STEP_IDX_MAX : v;
    endfunction

    function automatic logic [StepW-1:0] step_size(input logic [StepIdxW-1:0] idx);
        return STEP_ROM[clamp_idx(idx)];
    endfunction

endpackage

@@ hdl/adpcmnd_code_if.sv @@
// adpcmnd_code_if: input channel of the decoder, one code byte per beat.
// Standalone; no package dependency.
interface adpcmnd_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

@@ hdl/adpcmnd_sample_if.sv @@
// adpcmnd_sample_if: output channel of the decoder, one PCM sample pair per beat.
// Standalone; no package dependency.
interface adpcmnd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last;

    modport source (output valid, output left_sample, output right_sample,
                    output last, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input last, output ready);
endinterface

@@ hdl/adpcmnd_nibble.sv @@
// adpcmnd_nibble: combinational update of predictor and step index for one code.
// Depends on adpcmnd_pkg (step table, index adjust table, state struct).
module adpcmnd_nibble (
    input  adpcmnd_pkg::t_dec_state i_state,
    input  logic [3:0]              i_code,
    output adpcmnd_pkg::t_dec_state o_state
);

    logic [adpcmnd_pkg::StepW-1:0]   step;
    logic [adpcmnd_pkg::StepW+2:0]   prod;
    logic [15:0]                     mag;
    logic signed [17:0]              sum;
    logic signed [8:0]               idx_sum;

    always_comb begin
        step = adpcmnd_pkg::step_size(i_state.sidx);
        prod = {3'b000, step} * {15'd0, i_code[2:0]};
        mag  = prod[17:2];
        if (i_code[3]) begin
            sum = 18'(i_state.pred) - $signed({2'b00, mag});
        end else begin
            sum = 18'(i_state.pred) + $signed({2'b00, mag});
        end

        if (sum < -18'sd32768) begin
            o_state.pred = -16'sd32768;
        end else if (sum > 18'sd32767) begin
            o_state.pred = 16'sd32767;
        end else begin
            o_state.pred = sum[15:0];
        end

        idx_sum = $signed({2'b00, i_state.sidx})
                + 9'(adpcmnd_pkg::INDEX_ADJ[i_code]);
        if (idx_sum < 9'sd0) begin
            o_state.sidx = '0;
        end else if (idx_sum > $signed({2'b00, adpcmnd_pkg::STEP_IDX_MAX})) begin
            o_state.sidx = adpcmnd_pkg::STEP_IDX_MAX;
        end else begin
            o_state.sidx = idx_sum[6:0];
        end
    end

endmodule

@@ hdl/adpcm_nibble_decoder.sv @@
// adpcm_nibble_decoder: IMA-style 4-bit ADPCM decoder, two samples per code byte.
// Bytes pass input register, nibble update, output register; high nibble first.
// Throughput: one sample per cycle unless o_sample.ready stalls, set by the single
// nibble update unit. A new byte is taken as the last nibble fires; i_code.ready then follows o_sample.ready.
// Reset (sync, active low) clears predictor and step index to 0 and empties stages.
// Depends on adpcmnd_pkg, adpcmnd_code_if, adpcmnd_sample_if, adpcmnd_nibble.
module adpcm_nibble_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [adpcmnd_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [adpcmnd_pkg::CfgDataW-1:0]    i_cfg_data,
    adpcmnd_code_if.sink                        i_code,
    adpcmnd_sample_if.source                    o_sample
);

    logic [7:0]                         r_byte;
    logic                               r_busy;
    logic                               r_phase;
    adpcmnd_pkg::t_dec_state            r_state;
    logic                               r_out_valid;
    logic signed [15:0]                 r_out_sample;
    logic                               r_out_last;

    adpcmnd_pkg::t_dec_state            n_state;
    logic [3:0]                         code;
    logic                               out_free;
    logic                               fire;
    logic                               done;
    logic                               in_take;

    assign code     = r_phase ? r_byte[3:0] : r_byte[7:4];
    assign out_free = !r_out_valid || o_sample.ready;
    assign fire     = r_busy && out_free;
    assign done     = fire && r_phase;
    assign in_take  = i_code.valid && i_code.ready;

    assign i_code.ready          = !r_busy || done;
    assign o_sample.valid        = r_out_valid;
    assign o_sample.left_sample  = r_out_sample;
    assign o_sample.right_sample = r_out_sample;
    assign o_sample.last         = r_out_last;

    adpcmnd_nibble u_nibble (
        .i_state (r_state),
        .i_code  (code),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_byte  <= i_code.code_byte;
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
            end else if (done) begin
                r_busy  <= 1'b0;
                r_phase <= 1'b0;
            end else if (fire) begin
                r_phase <= 1'b1;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    adpcmnd_pkg::CFG_START_PRED: begin
                        r_state.pred <= i_cfg_data;
                    end
                    adpcmnd_pkg::CFG_START_SIDX: begin
                        r_state.sidx <= adpcmnd_pkg::clamp_idx(i_cfg_data[6:0]);
                    end
                    default: begin
                    end
                endcase
            end else if (fire) begin
                r_state <= n_state;
            end

            if (fire) begin
                r_out_valid  <= 1'b1;
                r_out_sample <= n_state.pred;
                r_out_last   <= r_phase;
            end else if (o_sample.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/adpcmnd_checker.sv @@
// adpcmnd_checker: port-level assertions for adpcm_nibble_decoder, plus its bind.
// Depends on the top level's port list only.
module adpcmnd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_left,
    input logic signed [15:0] i_right,
    input logic               i_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat valid right after reset");

    a_channels_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_left == i_right))
        else $error("left and right samples differ");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_left) && $stable(i_last)))
        else $error("stalled output beat changed");

endmodule

bind adpcm_nibble_decoder adpcmnd_checker u_adpcmnd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_sample.valid),
    .i_out_ready (o_sample.ready),
    .i_left      (o_sample.left_sample),
    .i_right     (o_sample.right_sample),
    .i_last      (o_sample.last)
);
